FILE: rtl/rlvs_pkg.sv
// Shared constants and types for the rate-limited velocity smoother.
`default_nettype none
package rlvs_pkg;

  localparam int XW       = 32;   // position width
  localparam int VW       = 17;   // velocity width
  localparam int TW       = 32;   // time width
  localparam int IDXW     = 11;   // point counter width
  localparam int SIW      = 10;   // start index width
  localparam int TAUW     = 20;   // time constant width
  localparam int ACCW     = 16;   // acceleration limit width
  localparam int IN_TDATA_W  = 152;
  localparam int OUT_TDATA_W = 56;
  localparam int PADDR_W  = 5;

  localparam int SQ_W     = 66;   // sum of three squares
  localparam int ROOT_W   = 33;
  localparam int NUM_W    = 50;   // divider numerator
  localparam int DEN_W    = 33;   // divider denominator
  localparam int ITER_W   = 6;
  localparam int SQRT_STEPS = 33;
  localparam int DIV_STEPS  = 50;

  localparam logic [IDXW-1:0] COUNT_CAP      = 11'd2047;
  localparam logic [TW-1:0]   MIN_DT_TICKS   = 32'd7;
  localparam logic [VW-1:0]   MIN_TIME_SPEED = 17'd102;
  localparam logic [TW-1:0]   TIME_MAX       = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    REG_START_INDEX    = 3'd0,
    REG_START_VELOCITY = 3'd1,
    REG_ACC_LIMIT      = 3'd2,
    REG_TIME_CONSTANT  = 3'd3,
    REG_TEMPORAL_MODE  = 3'd4
  } reg_idx_t;

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_SQX   = 17'h00002,
    S_SQY   = 17'h00004,
    S_SQZ   = 17'h00008,
    S_SQS   = 17'h00010,
    S_SQRT2 = 17'h00020,
    S_DIVDT = 17'h00040,
    S_MULA  = 17'h00080,
    S_MULB  = 17'h00100,
    S_MULL  = 17'h00200,
    S_FDEN  = 17'h00400,
    S_DIVF  = 17'h00800,
    S_CLAMP = 17'h01000,
    S_TIME  = 17'h02000,
    S_SQRT3 = 17'h04000,
    S_DIVT  = 17'h08000,
    S_DONE  = 17'h10000
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/rate_limited_velocity_smoother_top.sv
// Rate-limited velocity smoother: sequencer around one multiplier, one divider and one root unit.
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+------------------------------------------------
//  s_*      | in  | s_tvalid / s_tready   | s_tdata: x, y, z, velocity_in, time_in; s_tuser: first_point
//  m_*      | out | m_tvalid / m_tready   | m_tdata: velocity_out, time_out; m_tuser: saturated
//  apb      | in  | psel, penable, pready | paddr, pwdata, prdata (five registers)
//
// A point takes the shortest path when it is forced or passed in temporal mode and the
// longest when it is filtered in spatial mode: two 33-step square roots and up to three
// 50-step divisions run one after another on the shared root and divider units.
// s_tready is high only while the sequencer is idle; a finished result sits in the
// output register while the next point is taken. Reset is synchronous and clears all
// trajectory state and restores the register defaults.
`default_nettype none
module rate_limited_velocity_smoother_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // point_x[31:0], point_y[63:32], point_z[95:64], velocity_in[112:96], time_in[144:113]
  input  wire logic [rlvs_pkg::IN_TDATA_W-1:0]  s_tdata,
  // first_point[0]
  input  wire logic [0:0]                       s_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // velocity_out[16:0], time_out[48:17]
  output logic [rlvs_pkg::OUT_TDATA_W-1:0]      m_tdata,
  // saturated[0]
  output logic [0:0]                            m_tuser,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [rlvs_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [31:0]                      pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);
  import rlvs_pkg::*;

  state_t state;

  // Configuration registers.
  logic [SIW-1:0]         start_index;
  logic signed [VW-1:0]   start_velocity;
  logic [ACCW-1:0]        acc_limit;
  logic [TAUW-1:0]        time_constant;
  logic                   temporal_mode;

  // Trajectory state.
  logic [IDXW-1:0]        point_count;
  logic signed [VW-1:0]   fv;
  logic [XW-1:0]          prev_x, prev_y, prev_z;
  logic signed [VW-1:0]   prev_vout;
  logic [TW-1:0]          prev_tin, prev_tout;

  // Current point.
  logic [XW-1:0]          cur_x, cur_y, cur_z;
  logic signed [VW-1:0]   cur_v;
  logic [TW-1:0]          cur_t;
  logic [IDXW-1:0]        cur_idx;
  logic                   filt;
  logic [XW-1:0]          dx, dy, dz;
  logic [TW-1:0]          dt;
  logic signed [VW-1:0]   vout;
  logic [TW-1:0]          tout;
  logic                   sat;
  logic signed [NUM_W-1:0] fnum;
  logic                   fneg;
  logic [TW-1:0]          lim;
  logic signed [VW:0]     upd;
  logic [SQ_W-1:0]        sum2, sum3;

  // Shared multiplier.
  logic signed [32:0]     mul_a, mul_b;
  logic signed [65:0]     mul_p;

  // Root unit.
  logic [SQ_W-1:0]        sq_rad;
  logic [ROOT_W:0]        sq_rem;
  logic [ROOT_W-1:0]      sq_root;
  logic [ROOT_W+2:0]      sq_rem_sh, sq_trial, sq_diff;
  logic                   sq_ge;
  logic [ROOT_W-1:0]      sq_root_next;
  logic [ROOT_W:0]        sq_rem_next;

  // Divider unit.
  logic [NUM_W-1:0]       dv_quo;
  logic [DEN_W-1:0]       dv_rem, dv_den;
  logic [DEN_W:0]         dv_rem_sh, dv_diff;
  logic                   dv_ge;
  logic [NUM_W-1:0]       dv_quo_next;
  logic [DEN_W-1:0]       dv_rem_next;
  logic                   dv_ovf;
  logic [TW-1:0]          dv_q32;

  logic [ITER_W-1:0]      iter;
  logic                   sq_last, dv_last;

  // Input decode and combinational helpers.
  logic [XW-1:0]          in_x, in_y, in_z;
  logic signed [VW-1:0]   in_v;
  logic [TW-1:0]          in_t;
  logic [IDXW-1:0]        in_idx;
  logic                   in_pass, in_forced;
  logic signed [32:0]     ddx, ddy, ddz, tdiff;
  logic [VW-1:0]          fv_mag, pv_mag;
  logic [DEN_W-1:0]       den_f;
  logic [NUM_W-1:0]       fnum_mag;
  logic signed [VW+1:0]   diff;
  logic signed [33:0]     diff_w, lim_w, dcl;
  logic signed [VW-1:0]   fv_new;
  logic [TW-1:0]          inc;
  logic [TW:0]            tsum;
  logic [IDXW:0]          idx_inc;
  logic                   cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign s_tready = (state == S_IDLE);

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_START_INDEX:    prdata = {22'b0, start_index};
      REG_START_VELOCITY: prdata = 32'(start_velocity);
      REG_ACC_LIMIT:      prdata = {16'b0, acc_limit};
      REG_TIME_CONSTANT:  prdata = {12'b0, time_constant};
      REG_TEMPORAL_MODE:  prdata = {31'b0, temporal_mode};
      default:            prdata = 32'b0;
    endcase
  end

  always_comb begin
    in_x = s_tdata[31:0];
    in_y = s_tdata[63:32];
    in_z = s_tdata[95:64];
    in_v = $signed(s_tdata[112:96]);
    in_t = s_tdata[144:113];
    in_idx = s_tuser[0] ? '0 : point_count;
    in_pass = in_idx < {1'b0, start_index};
    in_forced = !in_pass && (in_idx <= ({1'b0, start_index} + 11'd1));
    ddx = $signed({in_x[31], in_x}) - $signed({prev_x[31], prev_x});
    ddy = $signed({in_y[31], in_y}) - $signed({prev_y[31], prev_y});
    ddz = $signed({in_z[31], in_z}) - $signed({prev_z[31], prev_z});
    tdiff = $signed({1'b0, in_t}) - $signed({1'b0, prev_tin});
    fv_mag = fv[VW-1] ? VW'(-fv) : VW'(fv);
    pv_mag = prev_vout[VW-1] ? VW'(-prev_vout) : VW'(prev_vout);
    den_f = {13'b0, time_constant} + {1'b0, dt};
    fnum_mag = fnum[NUM_W-1] ? NUM_W'(-fnum) : NUM_W'(fnum);
    idx_inc = {1'b0, cur_idx} + 12'd1;
  end

  // Multiplier operand selection by state.
  always_comb begin
    case (state)
      S_SQX:   begin mul_a = $signed({1'b0, dx}); mul_b = $signed({1'b0, dx}); end
      S_SQY:   begin mul_a = $signed({1'b0, dy}); mul_b = $signed({1'b0, dy}); end
      S_SQZ:   begin mul_a = $signed({1'b0, dz}); mul_b = $signed({1'b0, dz}); end
      S_MULA:  begin mul_a = $signed({13'b0, time_constant}); mul_b = 33'(fv); end
      S_MULB:  begin mul_a = $signed({1'b0, dt}); mul_b = 33'(cur_v); end
      S_MULL:  begin mul_a = $signed({17'b0, acc_limit}); mul_b = $signed({1'b0, dt}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // One root bit and one quotient bit per step.
  always_comb begin
    sq_rem_sh = {sq_rem, sq_rad[SQ_W-1:SQ_W-2]};
    sq_trial  = {1'b0, sq_root, 2'b01};
    sq_ge     = sq_rem_sh >= sq_trial;
    sq_diff   = sq_rem_sh - sq_trial;
    sq_rem_next  = sq_ge ? sq_diff[ROOT_W:0] : sq_rem_sh[ROOT_W:0];
    sq_root_next = {sq_root[ROOT_W-2:0], sq_ge};
    dv_rem_sh = {dv_rem, dv_quo[NUM_W-1]};
    dv_ge     = dv_rem_sh >= {1'b0, dv_den};
    dv_diff   = dv_rem_sh - {1'b0, dv_den};
    dv_rem_next = dv_ge ? dv_diff[DEN_W-1:0] : dv_rem_sh[DEN_W-1:0];
    dv_quo_next = {dv_quo[NUM_W-2:0], dv_ge};
    dv_ovf = |dv_quo_next[NUM_W-1:TW];
    dv_q32 = dv_ovf ? TIME_MAX : dv_quo_next[TW-1:0];
    sq_last = (iter == ITER_W'(SQRT_STEPS - 1));
    dv_last = (iter == ITER_W'(DIV_STEPS - 1));
    inc  = (dv_q32 < MIN_DT_TICKS) ? MIN_DT_TICKS : dv_q32;
    tsum = {1'b0, prev_tout} + {1'b0, inc};
  end

  // Step clamp against the acceleration limit.
  always_comb begin
    diff   = (VW+2)'(upd) - (VW+2)'(fv);
    diff_w = 34'(diff);
    lim_w  = $signed({2'b0, lim});
    if (diff_w > lim_w) begin
      dcl = lim_w;
    end else if (diff_w < -lim_w) begin
      dcl = -lim_w;
    end else begin
      dcl = diff_w;
    end
    fv_new = VW'(34'(fv) + dcl);
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    if (rst) begin
      state          <= S_IDLE;
      m_tvalid       <= 1'b0;
      start_index    <= '0;
      start_velocity <= '0;
      acc_limit      <= 16'd1024;
      time_constant  <= '0;
      temporal_mode  <= 1'b0;
      point_count    <= '0;
      fv             <= '0;
      prev_x         <= '0;
      prev_y         <= '0;
      prev_z         <= '0;
      prev_vout      <= '0;
      prev_tin       <= '0;
      prev_tout      <= '0;
    end else begin
      if (cfg_wr) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_START_INDEX:    start_index    <= pwdata[SIW-1:0];
          REG_START_VELOCITY: start_velocity <= $signed(pwdata[VW-1:0]);
          REG_ACC_LIMIT:      acc_limit      <= pwdata[ACCW-1:0];
          REG_TIME_CONSTANT:  time_constant  <= pwdata[TAUW-1:0];
          REG_TEMPORAL_MODE:  temporal_mode  <= pwdata[0];
          default: ;
        endcase
      end
      // In the done state the output register is handled below.
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cur_x   <= in_x;
            cur_y   <= in_y;
            cur_z   <= in_z;
            cur_v   <= in_v;
            cur_t   <= in_t;
            cur_idx <= in_idx;
            filt    <= !in_pass && !in_forced;
            dx <= ddx[32] ? 32'(-ddx) : ddx[31:0];
            dy <= ddy[32] ? 32'(-ddy) : ddy[31:0];
            dz <= ddz[32] ? 32'(-ddz) : ddz[31:0];
            dt <= (tdiff < 33'sd7) ? MIN_DT_TICKS : tdiff[31:0];
            sat <= 1'b0;
            if (in_pass) begin
              vout <= in_v;
            end else if (in_forced) begin
              vout <= start_velocity;
              fv   <= start_velocity;
            end
            state <= S_SQX;
          end
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin
          sum2  <= SQ_W'(unsigned'(mul_p));
          state <= S_SQZ;
        end
        S_SQZ: begin
          sum2  <= sum2 + SQ_W'(unsigned'(mul_p));
          state <= S_SQS;
        end
        S_SQS: begin
          sum3 <= sum2 + SQ_W'(unsigned'(mul_p));
          if (!filt) begin
            state <= S_TIME;
          end else if (temporal_mode) begin
            state <= S_MULA;
          end else begin
            sq_rad  <= sum2;
            sq_rem  <= '0;
            sq_root <= '0;
            iter    <= '0;
            state   <= S_SQRT2;
          end
        end
        S_SQRT2: begin
          sq_rad  <= sq_rad << 2;
          sq_rem  <= sq_rem_next;
          sq_root <= sq_root_next;
          iter    <= iter + 1'b1;
          if (sq_last) begin
            dv_quo <= {1'b0, sq_root_next, 16'b0};
            dv_rem <= '0;
            dv_den <= {16'b0, (fv_mag == '0) ? 17'd1 : fv_mag};
            iter   <= '0;
            state  <= S_DIVDT;
          end
        end
        S_DIVDT: begin
          dv_quo <= dv_quo_next;
          dv_rem <= dv_rem_next;
          iter   <= iter + 1'b1;
          if (dv_last) begin
            dt    <= dv_q32;
            sat   <= sat | dv_ovf;
            state <= S_MULA;
          end
        end
        S_MULA: state <= S_MULB;
        S_MULB: begin
          fnum  <= mul_p[NUM_W-1:0];
          state <= S_MULL;
        end
        S_MULL: begin
          fnum  <= fnum + mul_p[NUM_W-1:0];
          state <= S_FDEN;
        end
        S_FDEN: begin
          lim <= mul_p[47:16];
          if (den_f == '0) begin
            upd   <= (VW+1)'(cur_v);
            state <= S_CLAMP;
          end else begin
            dv_quo <= fnum_mag + NUM_W'(den_f >> 1);
            dv_rem <= '0;
            dv_den <= den_f;
            fneg   <= fnum[NUM_W-1];
            iter   <= '0;
            state  <= S_DIVF;
          end
        end
        S_DIVF: begin
          dv_quo <= dv_quo_next;
          dv_rem <= dv_rem_next;
          iter   <= iter + 1'b1;
          if (dv_last) begin
            upd   <= fneg ? -$signed(dv_quo_next[VW:0]) : $signed(dv_quo_next[VW:0]);
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          fv    <= fv_new;
          vout  <= fv_new;
          state <= S_TIME;
        end
        S_TIME: begin
          if (temporal_mode) begin
            tout  <= cur_t;
            state <= S_DONE;
          end else if (cur_idx == '0) begin
            tout  <= '0;
            state <= S_DONE;
          end else begin
            sq_rad  <= sum3;
            sq_rem  <= '0;
            sq_root <= '0;
            iter    <= '0;
            state   <= S_SQRT3;
          end
        end
        S_SQRT3: begin
          sq_rad  <= sq_rad << 2;
          sq_rem  <= sq_rem_next;
          sq_root <= sq_root_next;
          iter    <= iter + 1'b1;
          if (sq_last) begin
            dv_quo <= {1'b0, sq_root_next, 16'b0};
            dv_rem <= '0;
            dv_den <= {16'b0, (pv_mag < MIN_TIME_SPEED) ? MIN_TIME_SPEED : pv_mag};
            iter   <= '0;
            state  <= S_DIVT;
          end
        end
        S_DIVT: begin
          dv_quo <= dv_quo_next;
          dv_rem <= dv_rem_next;
          iter   <= iter + 1'b1;
          if (dv_last) begin
            sat   <= sat | dv_ovf | tsum[TW];
            tout  <= tsum[TW] ? TIME_MAX : tsum[TW-1:0];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // Hold here while the previous result has not been taken.
          if (!m_tvalid || m_tready) begin
            m_tvalid    <= 1'b1;
            m_tdata     <= {7'b0, tout, vout};
            m_tuser[0]  <= sat;
            prev_x      <= cur_x;
            prev_y      <= cur_y;
            prev_z      <= cur_z;
            prev_vout   <= vout;
            prev_tin    <= cur_t;
            prev_tout   <= tout;
            point_count <= idx_inc[IDXW] ? COUNT_CAP : idx_inc[IDXW-1:0];
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
